[rtl/core/dbd_pkg.sv]
// ============================================================================
// Days-between-dates package
// Shared widths, constants, microcode word layout and small helper functions.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

  // Field widths of the transfers.
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;

  // Accumulator holds a day number of any 14-bit year (below 2**23).
  localparam int unsigned AccW   = 23;
  localparam int unsigned PcW    = 4;
  localparam int unsigned MonTabW = 9;

  // Division by 100 as floor(floor(v / 4) * 5243 / 2**17).
  localparam int unsigned QW         = 8;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned RecipShift = 17;
  localparam int unsigned ProdW      = YearW - 2 + RecipW;
  localparam logic [RecipW-1:0] Recip25 = RecipW'(5243);

  localparam logic [8:0]        DaysPerYear = 9'd365;
  localparam logic [6:0]        Hundred     = 7'd100;
  localparam logic [MonW-1:0]   MonthJan    = MonW'(1);
  localparam logic [MonW-1:0]   MonthFeb    = MonW'(2);
  localparam logic [MonW-1:0]   MonthDec    = MonW'(12);
  localparam logic [CountW-1:0] DayCountMax = '1;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_LOAD_MUL,
    ALU_ADD,
    ALU_SUB,
    ALU_ABSDIFF
  } alu_op_e;

  typedef enum logic [2:0] {
    OPD_ONE,
    OPD_X_DIV4,
    OPD_Q,
    OPD_Q_DIV4,
    OPD_MONTH,
    OPD_DAY
  } opd_sel_e;

  typedef enum logic [1:0] {
    QLD_NONE,
    QLD_X,
    QLD_Y
  } q_load_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_YEAR_ZERO,
    JMP_NO_LEAP_DAY,
    JMP_FIRST_DATE,
    JMP_END
  } jump_e;

  // One control word of the program.
  typedef struct packed {
    alu_op_e        alu_op;
    opd_sel_e       opd_sel;
    logic           load_x;
    q_load_e        q_load;
    logic           load_leap;
    logic           save_first;
    logic           emit;
    jump_e          jump;
    logic [PcW-1:0] target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic start;
    logic step_en;
  } seq_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic year_zero;
    logic leap_day;
    logic first_date;
    logic out_full;
  } dp_status_t;

  typedef struct packed {
    logic [DayW-1:0]  first_day;
    logic [MonW-1:0]  first_month;
    logic [YearW-1:0] first_year;
    logic [DayW-1:0]  second_day;
    logic [MonW-1:0]  second_month;
    logic [YearW-1:0] second_year;
  } date_pair_t;

  function automatic logic [QW-1:0] div100(input logic [YearW-1:0] v);
    logic [ProdW-1:0] prod;
    prod = ProdW'(v[YearW-1:2]) * ProdW'(Recip25);
    return prod[RecipShift +: QW];
  endfunction

  // Days in the months before month m of a common year, m in 1..12.
  function automatic logic [MonTabW-1:0] days_before_month(input logic [MonW-1:0] m);
    logic [MonTabW-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dbd_in_if.sv]
// ============================================================================
// Date pair channel
// Valid/ready channel that carries the two dates of one request.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface dbd_in_if
  import dbd_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [DayW-1:0]  first_day;
  logic [MonW-1:0]  first_month;
  logic [YearW-1:0] first_year;
  logic [DayW-1:0]  second_day;
  logic [MonW-1:0]  second_month;
  logic [YearW-1:0] second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );

endinterface

`default_nettype wire

[rtl/core/dbd_out_if.sv]
// ============================================================================
// Day count channel
// Valid/ready channel that carries one day count result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface dbd_out_if
  import dbd_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [CountW-1:0] day_count;

  modport source (
    output valid, day_count,
    input  ready
  );

  modport sink (
    input  valid, day_count,
    output ready
  );

endinterface

`default_nettype wire

[rtl/core/days_between_dates.sv]
// ============================================================================
// Days between dates
// Distance in days between two Gregorian dates, run by a microcode program.
// ============================================================================
// Usage:
//   A request is one transfer on in_i carrying two dates (day, month, year
//   each). The answer is one transfer on out_o carrying day_count, the
//   absolute number of days between the two dates, saturated to 22 bits.
//   Each date becomes a linear day number counted from year zero of the
//   proleptic Gregorian calendar; the result is the distance of the two.
//   After the input transfer the program runs 14 to 24 steps (11 steps
//   per date, one fewer when no leap day applies, 6 or 7 for year zero,
//   plus 2 closing steps). The result is valid from the edge that ends
//   the last step. A new request is taken only once the program is done
//   with the last one, as every step of the program goes through the
//   single accumulator.
//   in_i.ready is high whenever no request is in work. A finished result
//   sits in the output register, so a new request is accepted while it
//   waits; if the receiver still stalls when the next result is ready, the
//   program holds on its final step until the register frees up.
//   Reset clears the sequencer and the output valid flag; the block comes
//   out of reset idle and ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module days_between_dates
  import dbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dbd_in_if.sink     in_i,
  dbd_out_if.source  out_o
);

  date_pair_t     dates;
  uword_t         uword;
  seq_ctrl_t      ctrl;
  dp_status_t     status;
  logic [PcW-1:0] pc;

  // Gather the request payload into one bundle for the datapath.
  assign dates.first_day    = in_i.first_day;
  assign dates.first_month  = in_i.first_month;
  assign dates.first_year   = in_i.first_year;
  assign dates.second_day   = in_i.second_day;
  assign dates.second_month = in_i.second_month;
  assign dates.second_year  = in_i.second_year;

  // The step counter addresses the program; the control word it reads
  // drives both the jump logic and the datapath in the same cycle.
  dbd_ucode_rom u_rom (
    .pc_i    (pc),
    .uword_o (uword)
  );

  dbd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .uword_i    (uword),
    .status_i   (status),
    .pc_o       (pc),
    .ctrl_o     (ctrl)
  );

  dbd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dates_i     (dates),
    .ctrl_i      (ctrl),
    .uword_i     (uword),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .day_count_o (out_o.day_count)
  );

endmodule

`default_nettype wire

[rtl/core/dbd_ucode_rom.sv]
// ============================================================================
// Microcode ROM
// Program that turns each date into a day number and forms the distance.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbd_ucode_rom
  import dbd_pkg::*;
(
  input  logic [PcW-1:0] pc_i,
  output uword_t         uword_o
);

  function automatic uword_t uw(input alu_op_e op, input opd_sel_e opd,
                                input logic ldx, input q_load_e qld,
                                input logic ldl, input logic save,
                                input logic emit, input jump_e jmp,
                                input logic [PcW-1:0] tgt);
    uword_t w;
    w.alu_op     = op;
    w.opd_sel    = opd;
    w.load_x     = ldx;
    w.q_load     = qld;
    w.load_leap  = ldl;
    w.save_first = save;
    w.emit       = emit;
    w.jump       = jmp;
    w.target     = tgt;
    return w;
  endfunction

  // Each date runs a path through steps 0 to 10; steps 11 and 12 close the request.
  always_comb begin
    unique case (pc_i)
      // acc = 365 * year, x = year - 1; year zero has no earlier years.
      4'd0:  uword_o = uw(ALU_LOAD_MUL, OPD_ONE, 1'b1, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_YEAR_ZERO, 4'd5);
      // Year zero itself is a leap year; q = x / 100.
      4'd1:  uword_o = uw(ALU_ADD, OPD_ONE, 1'b0, QLD_X, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd2:  uword_o = uw(ALU_ADD, OPD_X_DIV4, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd3:  uword_o = uw(ALU_SUB, OPD_Q, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd4:  uword_o = uw(ALU_ADD, OPD_Q_DIV4, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      // q = year / 100 for the leap test.
      4'd5:  uword_o = uw(ALU_NOP, OPD_ONE, 1'b0, QLD_Y, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd6:  uword_o = uw(ALU_ADD, OPD_MONTH, 1'b0, QLD_NONE, 1'b1, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd7:  uword_o = uw(ALU_NOP, OPD_ONE, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NO_LEAP_DAY, 4'd9);
      4'd8:  uword_o = uw(ALU_ADD, OPD_ONE, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd9:  uword_o = uw(ALU_ADD, OPD_DAY, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd10: uword_o = uw(ALU_NOP, OPD_ONE, 1'b0, QLD_NONE, 1'b0, 1'b1, 1'b0,
                          JMP_FIRST_DATE, 4'd0);
      4'd11: uword_o = uw(ALU_ABSDIFF, OPD_ONE, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                          JMP_NEXT, 4'd0);
      4'd12: uword_o = uw(ALU_NOP, OPD_ONE, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b1,
                          JMP_END, 4'd0);
      default: uword_o = uw(ALU_NOP, OPD_ONE, 1'b0, QLD_NONE, 1'b0, 1'b0, 1'b0,
                            JMP_END, 4'd0);
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/dbd_sequencer.sv]
// ============================================================================
// Microcode sequencer
// Step counter with conditional jumps; owns the input handshake.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbd_sequencer
  import dbd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uword_t         uword_i,
  input  dp_status_t     status_i,
  output logic [PcW-1:0] pc_o,
  output seq_ctrl_t      ctrl_o
);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           take;
  logic           stall;

  assign in_ready_o = ~busy_q;
  assign pc_o       = pc_q;

  // The result step waits while the output register holds a result not yet taken.
  assign stall          = uword_i.emit & status_i.out_full;
  assign ctrl_o.start   = in_valid_i & ~busy_q;
  assign ctrl_o.step_en = busy_q & ~stall;

  always_comb begin
    case (uword_i.jump)
      JMP_YEAR_ZERO:   take = status_i.year_zero;
      JMP_NO_LEAP_DAY: take = ~status_i.leap_day;
      JMP_FIRST_DATE:  take = status_i.first_date;
      default:         take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (ctrl_o.start) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (ctrl_o.step_en) begin
      if (uword_i.jump == JMP_END) begin
        busy_d = 1'b0;
        pc_d   = '0;
      end else if (take) begin
        pc_d = uword_i.target;
      end else begin
        pc_d = pc_q + PcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dbd_datapath.sv]
// ============================================================================
// Day number datapath
// Accumulator, divide-by-100 unit, leap test and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbd_datapath
  import dbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  date_pair_t        dates_i,
  input  seq_ctrl_t         ctrl_i,
  input  uword_t            uword_i,
  output dp_status_t        status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] day_count_o
);

  date_pair_t        dates_q;
  logic              sel_q;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   first_q;
  logic [YearW-1:0]  x_q;
  logic [QW-1:0]     q_q;
  logic              leap_q;
  logic              out_valid_q;
  logic [CountW-1:0] out_q;

  logic [DayW-1:0]   day;
  logic [MonW-1:0]   mon_raw, mon;
  logic [YearW-1:0]  year;
  logic [YearW-1:0]  rem100;
  logic              leap;
  logic [AccW-1:0]   opd;

  // The date in work: first while sel_q is low, second afterwards.
  assign day     = sel_q ? dates_q.second_day   : dates_q.first_day;
  assign mon_raw = sel_q ? dates_q.second_month : dates_q.first_month;
  assign year    = sel_q ? dates_q.second_year  : dates_q.first_year;

  // Month zero counts as January, anything past December as December.
  always_comb begin
    if (mon_raw < MonthJan) begin
      mon = MonthJan;
    end else if (mon_raw > MonthDec) begin
      mon = MonthDec;
    end else begin
      mon = mon_raw;
    end
  end

  // With q_q = year / 100, the year is a multiple of 100 when the
  // remainder is zero, and of 400 when q_q is also a multiple of 4.
  assign rem100 = year - (YearW'(q_q) * YearW'(Hundred));
  assign leap   = (year[1:0] == 2'b00) && ((rem100 != '0) || (q_q[1:0] == 2'b00));

  always_comb begin
    case (uword_i.opd_sel)
      OPD_X_DIV4: opd = AccW'(x_q[YearW-1:2]);
      OPD_Q:      opd = AccW'(q_q);
      OPD_Q_DIV4: opd = AccW'(q_q[QW-1:2]);
      OPD_MONTH:  opd = AccW'(days_before_month(mon));
      OPD_DAY:    opd = AccW'(day);
      default:    opd = AccW'(1);
    endcase
  end

  always_comb begin
    case (uword_i.alu_op)
      ALU_LOAD_MUL: acc_d = AccW'(year) * AccW'(DaysPerYear);
      ALU_ADD:      acc_d = acc_q + opd;
      ALU_SUB:      acc_d = acc_q - opd;
      ALU_ABSDIFF:  acc_d = (first_q >= acc_q) ? (first_q - acc_q) : (acc_q - first_q);
      default:      acc_d = acc_q;
    endcase
  end

  assign status_o.year_zero  = (year == '0);
  assign status_o.leap_day   = leap_q && (mon > MonthFeb);
  assign status_o.first_date = ~sel_q;
  assign status_o.out_full   = out_valid_q & ~out_ready_i;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dates_q <= dates_i;
    end
    if (ctrl_i.step_en) begin
      acc_q <= acc_d;
      if (uword_i.load_x) begin
        x_q <= year - YearW'(1);
      end
      if (uword_i.q_load == QLD_X) begin
        q_q <= div100(x_q);
      end else if (uword_i.q_load == QLD_Y) begin
        q_q <= div100(year);
      end
      if (uword_i.load_leap) begin
        leap_q <= leap;
      end
      if (uword_i.save_first && !sel_q) begin
        first_q <= acc_q;
      end
      if (uword_i.emit) begin
        out_q <= (acc_q > AccW'(DayCountMax)) ? DayCountMax : acc_q[CountW-1:0];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.start) begin
        sel_q <= 1'b0;
      end else if (ctrl_i.step_en && uword_i.save_first) begin
        sel_q <= 1'b1;
      end
      if (ctrl_i.step_en && uword_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_count_o = out_q;

endmodule

`default_nettype wire

[tb/days_between_dates_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day count checker
// Watches both channels of the days-between-dates block, predicts the day
// count of every accepted date pair and compares it with the returned results
// in order.
// ----------------------------------------------------------------------------

module days_between_dates_checker
  import dbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  date_pair_t        in_pair_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CountW-1:0] out_day_count_i,
  output int                fail_count_o,
  output int                pending_o
);

  // Day counts still owed by the block, oldest first.
  logic [CountW-1:0] due_counts[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Linear day number counted from year zero of the proleptic calendar.
  // Out-of-range months are clamped; the day is added as it comes.
  function automatic int unsigned day_index(input logic [DayW-1:0]  d,
                                            input logic [MonW-1:0]  m,
                                            input logic [YearW-1:0] y);
    int unsigned mon;
    int unsigned yr;
    int unsigned prior;
    int unsigned n;
    yr  = y;
    mon = m;
    if (m < MonthJan) begin
      mon = MonthJan;
    end
    if (m > MonthDec) begin
      mon = MonthDec;
    end
    n = 365 * yr;
    if (yr >= 1) begin
      prior = yr - 1;
      n = n + prior / 4 - prior / 100 + prior / 400 + 1;
    end
    for (int i = 1; i < mon; i++) begin
      n = n + month_days(i, yr);
    end
    return n + d;
  endfunction

  function automatic logic [CountW-1:0] days_apart(input date_pair_t p);
    int unsigned a;
    int unsigned b;
    int unsigned gap;
    a   = day_index(p.first_day, p.first_month, p.first_year);
    b   = day_index(p.second_day, p.second_month, p.second_year);
    gap = (a > b) ? a - b : b - a;
    if (gap > DayCountMax) begin
      gap = DayCountMax;
    end
    return gap[CountW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns  day count check failed: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin : watch
    logic [CountW-1:0] want;
    if (rst_ni) begin
      // Retire a result before queueing a new pair, so that a result can
      // never be matched with a request accepted in the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (due_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", out_day_count_i));
        end else begin
          want = due_counts.pop_front();
          if (out_day_count_i !== want) begin
            report_mismatch($sformatf("day_count got %0d, want %0d", out_day_count_i, want));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_counts.push_back(days_apart(in_pair_i));
      end
      pending_o = due_counts.size();
    end
  end

endmodule

[tb/days_between_dates_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Days-between-dates testbench
// Sends a directed set of date pairs and then random pairs under several
// patterns of sender gaps and receiver stalls, including one long receiver
// hold-off. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module days_between_dates_test;
  import dbd_pkg::*;

  // The run is far shorter than this; the limit only catches a hang.
  localparam int unsigned LimitNs   = 12_000_000;
  localparam int unsigned DrainCyc  = 40;
  localparam int unsigned HoldCyc   = 300;
  localparam int unsigned PhaseSize = 400;

  logic clk;
  logic rst_n;

  dbd_in_if  in_if ();
  dbd_out_if out_if ();

  date_pair_t watched_pair;
  int         fail_count;
  int         pending;

  // Idle and stall rates in percent, set per phase by the stimulus.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // The stimulus bumps hold_seq to ask the receiver for a long hold-off.
  int unsigned hold_seq;
  int unsigned hold_seen;
  int unsigned hold_left;

  days_between_dates u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  assign watched_pair = {in_if.first_day, in_if.first_month, in_if.first_year,
                         in_if.second_day, in_if.second_month, in_if.second_year};

  days_between_dates_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_if.valid),
    .in_ready_i      (in_if.ready),
    .in_pair_i       (watched_pair),
    .out_valid_i     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_day_count_i (out_if.day_count),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hang guard.
  initial begin
    #LimitNs;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver. Normally it stalls at the phase's random rate; on request it
  // holds ready low for a long stretch so that the block backs up.
  initial begin
    out_if.ready = 1'b0;
    hold_seen    = 0;
    hold_left    = 0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready = 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen    = hold_seq;
      hold_left    = HoldCyc;
      out_if.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic date_pair_t pair_of(input int unsigned fd, input int unsigned fm,
                                         input int unsigned fy, input int unsigned sd,
                                         input int unsigned sm, input int unsigned sy);
    date_pair_t p;
    p.first_day    = fd[DayW-1:0];
    p.first_month  = fm[MonW-1:0];
    p.first_year   = fy[YearW-1:0];
    p.second_day   = sd[DayW-1:0];
    p.second_month = sm[MonW-1:0];
    p.second_year  = sy[YearW-1:0];
    return p;
  endfunction

  // Plausible year: mostly anywhere in 1..9999, sometimes a century year so
  // that the hundred and four-hundred rules are hit often.
  function automatic int unsigned pick_year();
    if ($urandom_range(99) < 20) begin
      return $urandom_range(99, 1) * 100;
    end
    return $urandom_range(9999, 1);
  endfunction

  // Random pair. Most pairs are well-formed dates; some are near each other
  // (same year, adjacent years, around February); the rest is raw noise
  // over the whole width of every field.
  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int unsigned kind;
    logic [63:0] noise;
    kind = $urandom_range(99);
    if (kind < 15) begin
      noise = {$urandom(), $urandom()};
      p     = noise[$bits(date_pair_t)-1:0];
    end else begin
      p = pair_of($urandom_range(28, 1), $urandom_range(12, 1), pick_year(),
                  $urandom_range(28, 1), $urandom_range(12, 1), pick_year());
      if ($urandom_range(9) == 0) begin
        p.first_day = DayW'($urandom_range(31, 1));
      end
      if (kind < 40) begin
        // Close dates: same year or one year apart.
        p.second_year = p.first_year + YearW'($urandom_range(1, 0));
        if (p.second_year > 9999) begin
          p.second_year = p.first_year;
        end
        if ($urandom_range(3) == 0) begin
          p.first_month  = MonthFeb;
          p.second_month = MonthFeb + MonW'(1);
          p.second_day   = DayW'($urandom_range(3, 1));
        end
      end
    end
    return p;
  endfunction

  // One transfer on the request channel. Valid is left high after the
  // transfer; the next call either offers a new pair or drops it.
  task automatic send_pair(input date_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.first_day    = p.first_day;
    in_if.first_month  = p.first_month;
    in_if.first_year   = p.first_year;
    in_if.second_day   = p.second_day;
    in_if.second_month = p.second_month;
    in_if.second_year  = p.second_year;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      send_pair(random_pair());
    end
  endtask

  initial begin
    date_pair_t edge_pairs[$];

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.first_day    = '0;
    in_if.first_month  = '0;
    in_if.first_year   = '0;
    in_if.second_day   = '0;
    in_if.second_month = '0;
    in_if.second_year  = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_seq           = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Identical dates give zero.
    edge_pairs.push_back(pair_of(14, 7, 1989, 14, 7, 1989));
    // Whole legal span, and the same pair with the earlier date second.
    edge_pairs.push_back(pair_of(1, 1, 1, 31, 12, 9999));
    edge_pairs.push_back(pair_of(31, 12, 9999, 1, 1, 1));
    // Widest span the fields allow: far beyond the count range, saturates.
    edge_pairs.push_back(pair_of(0, 0, 0, 31, 15, 16383));
    // All fields at their maximum on both sides.
    edge_pairs.push_back(pair_of(31, 15, 16383, 31, 15, 16383));
    // Same year, different months.
    edge_pairs.push_back(pair_of(1, 1, 2021, 1, 3, 2021));
    edge_pairs.push_back(pair_of(15, 11, 2020, 15, 2, 2020));
    // Leap rules: every fourth year, not a century, but every fourth century.
    edge_pairs.push_back(pair_of(28, 2, 2024, 1, 3, 2024));
    edge_pairs.push_back(pair_of(28, 2, 2023, 1, 3, 2023));
    edge_pairs.push_back(pair_of(28, 2, 1900, 1, 3, 1900));
    edge_pairs.push_back(pair_of(28, 2, 2000, 1, 3, 2000));
    // Day past the end of the month and day zero run on linearly.
    edge_pairs.push_back(pair_of(31, 2, 2021, 3, 3, 2021));
    edge_pairs.push_back(pair_of(0, 3, 2021, 28, 2, 2021));
    // Month zero acts as January, thirteen and above as December.
    edge_pairs.push_back(pair_of(5, 0, 2010, 5, 1, 2010));
    edge_pairs.push_back(pair_of(5, 13, 2010, 5, 12, 2010));
    edge_pairs.push_back(pair_of(5, 14, 2010, 20, 15, 2011));
    // Year zero is a leap year of the proleptic calendar.
    edge_pairs.push_back(pair_of(1, 1, 0, 1, 1, 1));
    edge_pairs.push_back(pair_of(29, 2, 0, 1, 3, 0));
    // Years above the legal range.
    edge_pairs.push_back(pair_of(1, 1, 10000, 1, 1, 16383));
    edge_pairs.push_back(pair_of(1, 1, 9999, 1, 1, 10000));
    foreach (edge_pairs[i]) begin
      send_pair(edge_pairs[i]);
    end

    // Back to back in both directions.
    run_phase(0, 0, PhaseSize);

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the block stops taking requests.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = hold_seq + 1;
    repeat (40) begin
      send_pair(random_pair());
    end

    run_phase(87, 0, PhaseSize);
    run_phase(0, 87, PhaseSize);
    run_phase(34, 34, PhaseSize);

    in_if.valid    = 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DrainCyc) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[days_between_dates.f]
rtl/core/dbd_pkg.sv
rtl/core/dbd_in_if.sv
rtl/core/dbd_out_if.sv
rtl/core/dbd_ucode_rom.sv
rtl/core/dbd_sequencer.sv
rtl/core/dbd_datapath.sv
rtl/core/days_between_dates.sv
tb/days_between_dates_checker.sv
tb/days_between_dates_test.sv
